/* sv/ppucpu_pkg.sv */
// ppucpu_pkg: shared types, register codes and constants of the cpu register port
// depends on nothing; imported by ppucpu_spr, ppucpu_regs, the top level and the checker
package ppucpu_pkg;

  // sprite attribute memory geometry
  localparam int SPRITE_BYTES = 256;
  localparam int SPR_AW       = $clog2(SPRITE_BYTES);

  // access direction
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register numbers on the cpu side
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_SPR_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // address constants
  localparam logic [13:0] BUFFERED_TOP = 14'h3EFF;  // last address served through the buffer
  localparam logic [7:0]  ATTR_MASK    = 8'h1C;     // unused attribute bits
  localparam logic [1:0]  ATTR_SLOT    = 2'd2;      // byte of a sprite entry holding attributes
  localparam logic [14:0] STEP_ROW     = 15'h0020;
  localparam logic [14:0] STEP_ONE     = 15'h0001;

  // input word of one bus access
  typedef struct packed {
    logic       op;
    logic [2:0] reg_index;
    logic [7:0] wdata;
    logic [7:0] vram_rdata;
    logic [7:0] status_in;
  } in_word_t;

  // result word of one bus access
  typedef struct packed {
    logic [7:0]  rdata;
    logic [13:0] vram_addr;
    logic        vram_we;
    logic [7:0]  vram_wdata;
    logic        vblank_clear;
    logic [14:0] temp_addr;
    logic [2:0]  fine_x;
    logic [14:0] cur_addr;
  } out_word_t;

  // request from the register file to the sprite memory
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [SPR_AW-1:0] addr;
    logic [7:0]        wdata;
  } spr_req_t;

endpackage

/* sv/ppucpu_ram.sv */
// ppucpu_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing
module ppucpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/ppucpu_spr.sv */
// ppucpu_spr: sprite attribute memory with per-entry valid bits for the zero reset
// depends on ppucpu_pkg and ppucpu_ram
module ppucpu_spr
  import ppucpu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  spr_req_t   req,
  output logic [7:0] rdata
);

  logic [SPRITE_BYTES-1:0] vld_r;
  logic [SPRITE_BYTES-1:0] vld_nxt;
  logic                    hit_r;
  logic                    hit_nxt;
  logic [7:0]              ram_q;

  ppucpu_ram #(
    .WIDTH(8),
    .DEPTH(SPRITE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr),
    .waddr (req.addr),
    .wdata (req.wdata),
    .re    (req.rd),
    .raddr (req.addr),
    .rdata (ram_q)
  );

  // valid bits mark entries written since reset
  always_comb begin
    vld_nxt = vld_r;
    if (req.wr) begin
      vld_nxt[req.addr] = 1'b1;
    end
    hit_nxt = req.rd ? vld_r[req.addr] : hit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      hit_r <= hit_nxt;
    end
  end

  // an entry never written reads as zero
  assign rdata = hit_r ? ram_q : 8'h00;

endmodule

/* sv/ppucpu_regs.sv */
// ppucpu_regs: control, scroll and address registers, write toggle, read buffer
// depends on ppucpu_pkg; drives the sprite memory request
module ppucpu_regs
  import ppucpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  in_word_t  in_w,
  output out_word_t res,
  output spr_req_t  spr_req
);

  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [14:0]       cur_r, cur_nxt;
  logic [14:0]       tmp_r, tmp_nxt;
  logic [2:0]        fine_r, fine_nxt;
  logic              tog_r, tog_nxt;
  logic [SPR_AW-1:0] sidx_r, sidx_nxt;
  logic [7:0]        buf_r, buf_nxt;
  logic [7:0]        rb_r [8];
  logic [7:0]        wval;
  logic [7:0]        rd;
  logic              data_acc;
  logic              vclr;
  logic [14:0]       step;

  assign step = ctrl_r[2] ? STEP_ROW : STEP_ONE;

  // sprite data writes to the attribute byte clear the unused attribute bits
  assign wval = (in_w.reg_index == REG_SPR_DATA && sidx_r[1:0] == ATTR_SLOT) ?
                (in_w.wdata & ~ATTR_MASK) : in_w.wdata;

  // next state and result of one access
  always_comb begin
    ctrl_nxt = ctrl_r;
    cur_nxt  = cur_r;
    tmp_nxt  = tmp_r;
    fine_nxt = fine_r;
    tog_nxt  = tog_r;
    sidx_nxt = sidx_r;
    buf_nxt  = buf_r;
    rd       = 8'h00;
    data_acc = 1'b0;
    vclr     = 1'b0;
    spr_req  = '{rd: 1'b0, wr: 1'b0, addr: sidx_r, wdata: wval};
    if (in_w.op == OP_WRITE) begin
      case (in_w.reg_index)
        REG_CTRL: begin
          ctrl_nxt = in_w.wdata;
          tmp_nxt  = {tmp_r[14:12], in_w.wdata[1:0], tmp_r[9:0]};
        end
        REG_SPR_ADDR: begin
          sidx_nxt = in_w.wdata[SPR_AW-1:0];
        end
        REG_SPR_DATA: begin
          spr_req.wr = acc;
          sidx_nxt   = sidx_r + SPR_AW'(1);
        end
        REG_SCROLL: begin
          if (!tog_r) begin
            tmp_nxt  = {tmp_r[14:5], in_w.wdata[7:3]};
            fine_nxt = in_w.wdata[2:0];
            tog_nxt  = 1'b1;
          end else begin
            tmp_nxt = {in_w.wdata[2:0], tmp_r[11:10], in_w.wdata[7:3], tmp_r[4:0]};
            tog_nxt = 1'b0;
          end
        end
        REG_ADDR: begin
          if (!tog_r) begin
            tmp_nxt = {1'b0, in_w.wdata[5:0], tmp_r[7:0]};
            tog_nxt = 1'b1;
          end else begin
            tmp_nxt = {tmp_r[14:8], in_w.wdata};
            cur_nxt = {tmp_r[14:8], in_w.wdata};
            tog_nxt = 1'b0;
          end
        end
        REG_DATA: begin
          data_acc = 1'b1;
          cur_nxt  = cur_r + step;
        end
        default: begin
        end
      endcase
    end else begin
      case (in_w.reg_index)
        REG_STATUS: begin
          rd      = in_w.status_in;
          tog_nxt = 1'b0;
          vclr    = 1'b1;
        end
        REG_SPR_DATA: begin
          spr_req.rd = acc;
        end
        REG_DATA: begin
          data_acc = 1'b1;
          if (cur_r[13:0] <= BUFFERED_TOP) begin
            rd      = buf_r;
            buf_nxt = in_w.vram_rdata;
          end else begin
            rd = in_w.vram_rdata;
          end
          cur_nxt = cur_r + step;
        end
        default: begin
          rd = rb_r[in_w.reg_index];
        end
      endcase
    end
  end

  // result word, sprite data reads are filled in from memory later
  always_comb begin
    res.rdata        = rd;
    res.vram_addr    = data_acc ? cur_r[13:0] : cur_nxt[13:0];
    res.vram_we      = data_acc && (in_w.op == OP_WRITE);
    res.vram_wdata   = res.vram_we ? in_w.wdata : 8'h00;
    res.vblank_clear = vclr;
    res.temp_addr    = tmp_nxt;
    res.fine_x       = fine_nxt;
    res.cur_addr     = cur_nxt;
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
      cur_r  <= '0;
      tmp_r  <= '0;
      fine_r <= '0;
      tog_r  <= 1'b0;
      sidx_r <= '0;
      buf_r  <= '0;
    end else if (acc) begin
      ctrl_r <= ctrl_nxt;
      cur_r  <= cur_nxt;
      tmp_r  <= tmp_nxt;
      fine_r <= fine_nxt;
      tog_r  <= tog_nxt;
      sidx_r <= sidx_nxt;
      buf_r  <= buf_nxt;
    end
  end

  // last written byte per register, status writes leave it alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        rb_r[i] <= '0;
      end
    end else if (acc && in_w.op == OP_WRITE && in_w.reg_index != REG_STATUS) begin
      rb_r[in_w.reg_index] <= wval;
    end
  end

endmodule

/* sv/ppu_cpu_register_port.sv */
// ppu_cpu_register_port: cpu-side register file of the picture processor
// path: an accepted word passes the stage one register and then the output register to out_valid
// throughput: one word per cycle while out_ready is high; the sprite memory read port sets the two-stage path
// reset: synchronous active-low rst_n zeroes the state registers, valid flags and sprite valid bits at once
// depends on ppucpu_pkg, ppucpu_regs, ppucpu_spr
module ppu_cpu_register_port
  import ppucpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      acc;
  logic      s1_adv;
  logic      s1_v_r, s1_v_nxt;
  logic      out_v_r, out_v_nxt;
  logic      s1_spr_r;
  out_word_t s1_w_r;
  out_word_t s1_fill;
  out_word_t out_w_r;
  out_word_t res;
  spr_req_t  spr_req;
  logic [7:0] spr_rdata;

  ppucpu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_w    (in_word),
    .res     (res),
    .spr_req (spr_req)
  );

  ppucpu_spr u_spr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (spr_req),
    .rdata (spr_rdata)
  );

  // handshake: stage one waits for sprite memory data, output register is the skid
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || !out_v_r || out_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    s1_v_nxt  = acc || (s1_v_r && !s1_adv);
    out_v_nxt = s1_adv || (out_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // stage one word with the sprite byte merged in
  always_comb begin
    s1_fill       = s1_w_r;
    s1_fill.rdata = s1_spr_r ? spr_rdata : s1_w_r.rdata;
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_w_r   <= res;
      s1_spr_r <= spr_req.rd;
    end
    if (s1_adv) begin
      out_w_r <= s1_fill;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_w_r;

endmodule

/* sv/ppucpu_chk.sv */
// ppucpu_chk: port-level checks of the cpu register port, bound to the top level
// depends on ppucpu_pkg and ppu_cpu_register_port
module ppucpu_chk
  import ppucpu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // a video memory write is never a read result
  a_we_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.vram_we |-> !out_word.vblank_clear && out_word.rdata == 8'h00)
    else $error("write word carries read data");

  // write data only goes with a write strobe
  a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.vram_we |-> out_word.vram_wdata == 8'h00)
    else $error("write data without write strobe");

  // with both stages idle an offered word is taken
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(!in_valid) && $past(rst_n) |-> in_ready)
    else $error("idle block refused a word");

endmodule

bind ppu_cpu_register_port ppucpu_chk u_chk (.*);
